// ----- rtl/core/rhh_pkg.sv -----
package rhh_pkg;

    localparam int CAPACITY   = 1024;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(CAPACITY);
    localparam int CNT_W      = IDX_W + 1;

    localparam logic [1:0] FN_GET    = 2'd0;
    localparam logic [1:0] FN_PUT    = 2'd1;
    localparam logic [1:0] FN_REMOVE = 2'd2;

    localparam logic [2:0] RS_GET_HIT     = 3'd0;
    localparam logic [2:0] RS_GET_MISS    = 3'd1;
    localparam logic [2:0] RS_INSERTED    = 3'd2;
    localparam logic [2:0] RS_UPDATED     = 3'd3;
    localparam logic [2:0] RS_REFUSED     = 3'd4;
    localparam logic [2:0] RS_REMOVED     = 3'd5;
    localparam logic [2:0] RS_REMOVE_MISS = 3'd6;

    localparam logic [1:0] ADDR_FILL_LIMIT = 2'd0;

    localparam logic [10:0] FILL_LIMIT_RESET = 11'd870;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_INSERT,
        ST_SCAN,
        ST_SHIFT
    } state_t;

    typedef struct packed {
        logic [31:0]           hash;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } entry_t;

endpackage

// ----- rtl/core/robin_hood_hash_table.sv -----
// channel | handshake         | payload
// s_      | s_valid / s_ready | s_func, s_key, s_key_hash, s_value_in
// m_      | m_valid / m_ready | m_status, m_found_value, m_occupancy
// apb     | psel/penable      | paddr, pwdata, prdata (fill_limit at 0)
// After reset a clearing pass writes every slot, one slot a cycle, with s_ready low.
// After acceptance each item walks its probed slots through the single
// registered-read slot memory: lookup, then insert probes, or scan plus shift for remove.
// The result waits in an output register; the next item is taken once it is free or leaving.
module robin_hood_hash_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_func,
    input  logic [31:0] s_key,
    input  logic [31:0] s_key_hash,
    input  logic [31:0] s_value_in,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_found_value,
    output logic [10:0] m_occupancy,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rhh_pkg::*;

    state_t state_reg, state_next;

    entry_t mem [CAPACITY];
    entry_t rdata_reg;
    logic [IDX_W-1:0] rdpos_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;

    logic [IDX_W-1:0]      at_reg, at_next;
    logic [IDX_W-1:0]      where_reg, where_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      aux_reg, aux_next;
    logic [CNT_W-1:0]      used_reg, used_next;
    logic [1:0]            func_reg, func_next;
    logic [31:0]           h_reg, h_next;
    logic [KEY_BITS-1:0]   k_reg, k_next;
    logic [VALUE_BITS-1:0] v_reg, v_next;
    logic [10:0]           fill_limit_reg;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg, out_status_next;
    logic [31:0] out_value_reg, out_value_next;
    logic [10:0] out_occ_reg, out_occ_next;

    logic [31:0]      h_in;
    logic [IDX_W-1:0] probe_gap;
    logic             accept, empty, key_hit, lk_hit, lk_miss, refuse;
    logic             scan_end, scan_fail, ins_end, sh_end;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FILL_LIMIT) ? {21'd0, fill_limit_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_limit_reg <= FILL_LIMIT_RESET;
        end else if (psel && penable && pwrite) begin
            fill_limit_reg <= pwdata[10:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rdata_reg <= mem[rd_addr];
        rdpos_reg <= rd_addr;
    end

    assign s_ready       = (state_reg == ST_IDLE) && (!out_valid_reg || m_ready);
    assign accept        = s_valid && s_ready;
    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_found_value = out_value_reg;
    assign m_occupancy   = out_occ_reg;

    assign h_in      = (s_key_hash == 32'd0) ? 32'd1 : s_key_hash;
    assign probe_gap = rdpos_reg - rdata_reg.hash[IDX_W-1:0];
    assign empty     = (rdata_reg.hash == 32'd0);
    assign key_hit   = (rdata_reg.hash == h_reg) && (rdata_reg.key == k_reg);
    assign lk_hit    = !empty && key_hit;
    assign lk_miss   = empty || (!key_hit && (({1'b0, probe_gap} < cnt_reg)
                       || (cnt_reg == CNT_W'(CAPACITY - 1))));
    assign refuse    = (used_reg >= CNT_W'(fill_limit_reg)) || (used_reg >= CNT_W'(CAPACITY));
    assign scan_end  = empty || (probe_gap == '0);
    assign scan_fail = !scan_end && (cnt_reg == CNT_W'(CAPACITY - 2));
    assign ins_end   = empty || (cnt_reg == CNT_W'(CAPACITY - 1));
    assign sh_end    = (aux_reg == cnt_reg);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (at_reg == IDX_W'(CAPACITY - 1)) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) state_next = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (lk_hit) begin
                    state_next = (func_reg == FN_REMOVE) ? ST_SCAN : ST_IDLE;
                end else if (lk_miss) begin
                    state_next = (func_reg == FN_PUT && !refuse) ? ST_INSERT : ST_IDLE;
                end
            end
            ST_INSERT: begin
                if (ins_end) state_next = ST_IDLE;
            end
            ST_SCAN: begin
                if (scan_end) state_next = ST_SHIFT;
                else if (scan_fail) state_next = ST_IDLE;
            end
            ST_SHIFT: begin
                if (sh_end) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        at_next         = at_reg;
        where_next      = where_reg;
        cnt_next        = cnt_reg;
        aux_next        = aux_reg;
        used_next       = used_reg;
        func_next       = func_reg;
        h_next          = h_reg;
        k_next          = k_reg;
        v_next          = v_reg;
        rd_addr         = at_reg + IDX_W'(1);
        we              = 1'b0;
        wa              = at_reg;
        wd              = '0;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_value_next  = out_value_reg;
        out_occ_next    = out_occ_reg;
        if (out_valid_reg && m_ready) out_valid_next = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                we      = 1'b1;
                at_next = at_reg + IDX_W'(1);
            end
            ST_IDLE: begin
                rd_addr = h_in[IDX_W-1:0];
                if (accept) begin
                    func_next = s_func;
                    h_next    = h_in;
                    k_next    = s_key[KEY_BITS-1:0];
                    v_next    = s_value_in[VALUE_BITS-1:0];
                    at_next   = h_in[IDX_W-1:0];
                    cnt_next  = '0;
                end
            end
            ST_LOOKUP: begin
                if (lk_hit) begin
                    if (func_reg == FN_REMOVE) begin
                        where_next = at_reg;
                        cnt_next   = '0;
                    end else begin
                        out_valid_next = 1'b1;
                        out_occ_next   = 11'(used_reg);
                        out_value_next = 32'd0;
                        if (func_reg == FN_PUT) begin
                            we              = 1'b1;
                            wd              = '{rdata_reg.hash, rdata_reg.key, v_reg};
                            out_status_next = RS_UPDATED;
                        end else begin
                            out_value_next  = 32'(rdata_reg.value);
                            out_status_next = RS_GET_HIT;
                        end
                    end
                end else if (lk_miss) begin
                    if (func_reg == FN_PUT && !refuse) begin
                        at_next  = h_reg[IDX_W-1:0];
                        rd_addr  = h_reg[IDX_W-1:0];
                        cnt_next = '0;
                        aux_next = '0;
                    end else begin
                        out_valid_next  = 1'b1;
                        out_occ_next    = 11'(used_reg);
                        out_value_next  = 32'd0;
                        out_status_next = (func_reg == FN_PUT) ? RS_REFUSED :
                                          (func_reg == FN_REMOVE) ? RS_REMOVE_MISS :
                                          RS_GET_MISS;
                    end
                end else begin
                    at_next  = at_reg + IDX_W'(1);
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_INSERT: begin
                rd_addr  = at_reg + IDX_W'(1);
                at_next  = at_reg + IDX_W'(1);
                cnt_next = cnt_reg + CNT_W'(1);
                aux_next = aux_reg + CNT_W'(1);
                if (empty) begin
                    we        = 1'b1;
                    wd        = '{h_reg, k_reg, v_reg};
                    used_next = used_reg + CNT_W'(1);
                end else if (aux_reg > {1'b0, probe_gap}) begin
                    we       = 1'b1;
                    wd       = '{h_reg, k_reg, v_reg};
                    h_next   = rdata_reg.hash;
                    k_next   = rdata_reg.key;
                    v_next   = rdata_reg.value;
                    aux_next = {1'b0, probe_gap} + CNT_W'(1);
                end
                if (ins_end) begin
                    out_valid_next  = 1'b1;
                    out_occ_next    = 11'(used_next);
                    out_value_next  = 32'd0;
                    out_status_next = RS_INSERTED;
                end
            end
            ST_SCAN: begin
                rd_addr = rdpos_reg + IDX_W'(1);
                if (scan_end) begin
                    at_next  = where_reg;
                    aux_next = '0;
                    rd_addr  = where_reg + IDX_W'(1);
                end else if (scan_fail) begin
                    out_valid_next  = 1'b1;
                    out_occ_next    = 11'(used_reg);
                    out_value_next  = 32'd0;
                    out_status_next = RS_REMOVE_MISS;
                end else begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_SHIFT: begin
                we = 1'b1;
                if (sh_end) begin
                    wd              = '0;
                    used_next       = used_reg - CNT_W'(1);
                    out_valid_next  = 1'b1;
                    out_occ_next    = 11'(used_next);
                    out_value_next  = 32'd0;
                    out_status_next = RS_REMOVED;
                end else begin
                    wd       = rdata_reg;
                    at_next  = at_reg + IDX_W'(1);
                    aux_next = aux_reg + CNT_W'(1);
                    rd_addr  = at_reg + IDX_W'(2);
                end
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            at_reg        <= '0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            at_reg        <= at_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        where_reg      <= where_next;
        cnt_reg        <= cnt_next;
        aux_reg        <= aux_next;
        func_reg       <= func_next;
        h_reg          <= h_next;
        k_reg          <= k_next;
        v_reg          <= v_next;
        out_status_reg <= out_status_next;
        out_value_reg  <= out_value_next;
        out_occ_reg    <= out_occ_next;
    end

endmodule

// ----- test/tb.sv -----
module tb;
    import rhh_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int DRAIN_CYCLES   = 4200;
    localparam int RANDOM_ITEMS   = 1500;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] key;
        logic [31:0] key_hash;
        logic [31:0] value_in;
    } op_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] found_value;
        logic [10:0] occupancy;
    } reply_t;

    typedef struct {
        op_t        op;
        logic       typed;
        reply_t     reply;
    } row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_func = '0;
    logic [31:0] s_key = '0;
    logic [31:0] s_key_hash = '0;
    logic [31:0] s_value_in = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_found_value;
    logic [10:0] m_occupancy;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [1:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    robin_hood_hash_table DUT (.*);

    always #1 aclk = ~aclk;

    logic [31:0] tbl_hash [CAPACITY];
    logic [31:0] tbl_key  [CAPACITY];
    logic [31:0] tbl_val  [CAPACITY];
    int unsigned tbl_count;
    int unsigned limit_now;

    reply_t      replies_due [$];
    logic [31:0] live_keys [$];
    logic [31:0] live_hashes [$];
    int          errors = 0;
    int          send_idle = 30;
    int          recv_idle = 80;
    bit          recv_hold = 1'b0;
    int          idle_cycles = 0;

    function automatic int unsigned nxt(int unsigned i);
        return (i + 1 >= CAPACITY) ? 0 : i + 1;
    endfunction

    function automatic int unsigned home_gap(logic [31:0] h, int unsigned at);
        int unsigned home;
        home = h % CAPACITY;
        return (home <= at) ? at - home : at + CAPACITY - home;
    endfunction

    function automatic bit find_slot(logic [31:0] h, logic [31:0] k, output int unsigned where);
        int unsigned at;
        at = h % CAPACITY;
        where = 0;
        for (int unsigned i = 0; i < CAPACITY; i++) begin
            if (tbl_hash[at] == 0) return 0;
            if (tbl_hash[at] == h && tbl_key[at] == k) begin
                where = at;
                return 1;
            end
            if (home_gap(tbl_hash[at], at) < i) return 0;
            at = nxt(at);
        end
        return 0;
    endfunction

    function automatic void place_entry(logic [31:0] h, logic [31:0] k, logic [31:0] v);
        int unsigned at, probe, d;
        logic [31:0] th, tk, tv;
        at = h % CAPACITY;
        probe = 0;
        for (int unsigned i = 0; i < CAPACITY; i++) begin
            if (tbl_hash[at] == 0) begin
                tbl_hash[at] = h;
                tbl_key[at] = k;
                tbl_val[at] = v;
                tbl_count++;
                return;
            end
            d = home_gap(tbl_hash[at], at);
            if (probe > d) begin
                th = tbl_hash[at];
                tk = tbl_key[at];
                tv = tbl_val[at];
                tbl_hash[at] = h;
                tbl_key[at] = k;
                tbl_val[at] = v;
                h = th;
                k = tk;
                v = tv;
                probe = d;
            end
            probe++;
            at = nxt(at);
        end
    endfunction

    function automatic bit shift_out(int unsigned at);
        int unsigned cur, n, nx;
        cur = at;
        for (n = 0; n + 1 < CAPACITY; n++) begin
            nx = nxt(cur);
            if (tbl_hash[nx] == 0 || home_gap(tbl_hash[nx], nx) == 0) break;
            cur = nx;
        end
        if (n + 1 >= CAPACITY) return 0;
        cur = at;
        for (int unsigned i = 0; i < n; i++) begin
            nx = nxt(cur);
            tbl_hash[cur] = tbl_hash[nx];
            tbl_key[cur] = tbl_key[nx];
            tbl_val[cur] = tbl_val[nx];
            cur = nx;
        end
        tbl_hash[cur] = 0;
        tbl_count--;
        return 1;
    endfunction

    function automatic reply_t table_op(op_t op);
        reply_t r;
        logic [31:0] h;
        int unsigned where;
        r = '0;
        h = (op.key_hash == 0) ? 32'd1 : op.key_hash;
        if (op.func == FN_PUT) begin
            if (find_slot(h, op.key, where)) begin
                tbl_val[where] = op.value_in;
                r.status = RS_UPDATED;
            end else if (tbl_count >= limit_now || tbl_count >= CAPACITY) begin
                r.status = RS_REFUSED;
            end else begin
                place_entry(h, op.key, op.value_in);
                r.status = RS_INSERTED;
            end
        end else if (op.func == FN_REMOVE) begin
            if (find_slot(h, op.key, where) && shift_out(where)) r.status = RS_REMOVED;
            else r.status = RS_REMOVE_MISS;
        end else begin
            if (find_slot(h, op.key, where)) begin
                r.found_value = tbl_val[where];
                r.status = RS_GET_HIT;
            end else begin
                r.status = RS_GET_MISS;
            end
        end
        r.occupancy = tbl_count[10:0];
        return r;
    endfunction

    task automatic send(op_t op, bit typed = 0, reply_t want = '0);
        reply_t r;
        if ($urandom_range(99) < send_idle) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle);
        end
        s_valid <= 1'b1;
        s_func <= op.func;
        s_key <= op.key;
        s_key_hash <= op.key_hash;
        s_value_in <= op.value_in;
        do @(posedge aclk); while (!s_ready);
        r = table_op(op);
        replies_due.push_back(typed ? want : r);
        if (op.func == FN_PUT && r.status == RS_INSERTED) begin
            live_keys.push_back(op.key);
            live_hashes.push_back(op.key_hash);
        end
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (replies_due.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_limit(int unsigned v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= ADDR_FILL_LIMIT;
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        limit_now = v & 11'h7ff;
    endtask

    function automatic op_t rand_op(bit well);
        op_t o;
        int j;
        o.func = 2'($urandom_range(3));
        o.key = $urandom();
        o.key_hash = $urandom();
        o.value_in = $urandom();
        if (well) begin
            if ($urandom_range(3) == 0) o.func = FN_PUT;
            o.key = $urandom_range(255);
            o.key_hash = {$urandom_range(3) == 0 ? 32'd0 : $urandom()} & 32'hffff_f03f;
            if (live_keys.size() != 0 && $urandom_range(1)) begin
                j = $urandom_range(live_keys.size() - 1);
                o.key = live_keys[j];
                o.key_hash = live_hashes[j];
            end
        end
        return o;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= !recv_hold && ($urandom_range(99) >= recv_idle);
            if (m_valid && m_ready) begin
                if (replies_due.size() == 0) begin
                    $error("item with no expectation");
                    errors++;
                end else begin
                    reply_t w;
                    w = replies_due.pop_front();
                    if (m_status !== w.status) begin
                        $error("status exp %0d got %0d", w.status, m_status);
                        errors++;
                    end
                    if (m_found_value !== w.found_value) begin
                        $error("found_value exp %h got %h", w.found_value, m_found_value);
                        errors++;
                    end
                    if (m_occupancy !== w.occupancy) begin
                        $error("occupancy exp %0d got %0d", w.occupancy, m_occupancy);
                        errors++;
                    end
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || psel) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles > WATCHDOG_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    row_t rows [$];

    initial begin
        for (int i = 0; i < CAPACITY; i++) begin
            tbl_hash[i] = '0;
            tbl_key[i] = '0;
            tbl_val[i] = '0;
        end
        tbl_count = 0;
        limit_now = 870;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        rows.push_back('{'{FN_GET, 32'd5, 32'd5, 32'd0}, 1, '{RS_GET_MISS, 32'd0, 11'd0}});
        rows.push_back('{'{FN_REMOVE, 32'd5, 32'd5, 32'd0}, 1, '{RS_REMOVE_MISS, 32'd0, 11'd0}});
        rows.push_back('{'{FN_PUT, 32'hffff_ffff, 32'd0, 32'hffff_ffff}, 1,
                         '{RS_INSERTED, 32'd0, 11'd1}});
        rows.push_back('{'{2'd3, 32'hffff_ffff, 32'd1, 32'd0}, 1,
                         '{RS_GET_HIT, 32'hffff_ffff, 11'd1}});
        rows.push_back('{'{FN_PUT, 32'hffff_ffff, 32'd0, 32'h0}, 1, '{RS_UPDATED, 32'd0, 11'd1}});
        rows.push_back('{'{FN_PUT, 32'd0, 32'd1025, 32'h1234}, 0, '0});
        rows.push_back('{'{FN_PUT, 32'd7, 32'd1023, 32'h55}, 0, '0});
        rows.push_back('{'{FN_PUT, 32'd8, 32'd1023, 32'h66}, 0, '0});
        rows.push_back('{'{FN_PUT, 32'd9, 32'd2, 32'h77}, 0, '0});
        rows.push_back('{'{FN_GET, 32'd8, 32'd1023, 32'h0}, 0, '0});
        rows.push_back('{'{FN_GET, 32'd0, 32'd1025, 32'h0}, 0, '0});
        rows.push_back('{'{FN_REMOVE, 32'd7, 32'd1023, 32'h0}, 0, '0});
        rows.push_back('{'{FN_GET, 32'd9, 32'd2, 32'h0}, 0, '0});
        rows.push_back('{'{FN_REMOVE, 32'hffff_ffff, 32'd1, 32'h0}, 0, '0});
        rows.push_back('{'{FN_GET, 32'd8, 32'hffff_ffff, 32'h0}, 0, '0});
        foreach (rows[i]) send(rows[i].op, rows[i].typed, rows[i].reply);

        write_limit(0);
        send('{FN_PUT, 32'd100, 32'd100, 32'd1}, 1, '{RS_REFUSED, 32'd0, tbl_count[10:0]});
        send('{FN_PUT, 32'd8, 32'd1023, 32'd2});
        write_limit(2047);

        recv_hold = 1'b1;
        fork
            begin
                repeat (300) @(posedge aclk);
                recv_hold = 1'b0;
            end
            for (int i = 0; i < 20; i++) send(rand_op(1));
        join
        drain();

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 3) begin
                send_idle = 80;
                recv_idle = 30;
                write_limit($urandom_range(1, 40));
            end
            if (i == 2 * RANDOM_ITEMS / 3) begin
                send_idle = 0;
                recv_idle = 0;
                write_limit(1024);
            end
            if (i % 400 == 399) drain();
            send(rand_op($urandom_range(9) != 0));
        end
        drain();

        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
